>>> design/segment_clip_and_project_unit_macros.svh
// assertion macros for the segment clip and projection unit
// included by the top level; needs nothing else
`ifndef SEGMENT_CLIP_AND_PROJECT_UNIT_MACROS_SVH
`define SEGMENT_CLIP_AND_PROJECT_UNIT_MACROS_SVH
`ifndef SYNTH
`define SCPU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("scpu assertion failed");
`define SCPU_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("scpu assertion failed");
`else
`define SCPU_ASSERT(lbl, clk, rst, prop)
`define SCPU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> design/scpu_pkg.sv
// shared types and constants of the segment clip and projection unit
// no dependencies
package scpu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CRD_W     = 32;
   localparam int TRIG_W    = 18;
   localparam int DIM_W     = 14;
   localparam int NEAR_W    = 17;
   localparam int SCR_W     = 24;
   localparam int CSR_W     = 18;
   localparam int CSR_IDX_W = 3;

   localparam int ONE_FX     = 1 << FRAC_BITS;
   localparam int Z_MIN      = (ONE_FX + 500) / 1000;
   localparam int NEAR_RESET = (ONE_FX + 5) / 10;
   localparam int DIM_RESET  = 1200;

   localparam logic [SCR_W-1:0] SCR_MAX = {1'b0, {(SCR_W-1){1'b1}}};
   localparam logic [SCR_W-1:0] SCR_MIN = {1'b1, {(SCR_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_YAW_COS   = 3'd0,
      CSR_YAW_SIN   = 3'd1,
      CSR_PITCH_COS = 3'd2,
      CSR_PITCH_SIN = 3'd3,
      CSR_SCREEN_W  = 3'd4,
      CSR_SCREEN_H  = 3'd5,
      CSR_NEAR      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] ax;
      logic signed [CRD_W-1:0] ay;
      logic signed [CRD_W-1:0] az;
      logic signed [CRD_W-1:0] bx;
      logic signed [CRD_W-1:0] by;
      logic signed [CRD_W-1:0] bz;
   } req_type;

   typedef struct packed {
      logic                    visible;
      logic signed [SCR_W-1:0] sx0;
      logic signed [SCR_W-1:0] sy0;
      logic signed [SCR_W-1:0] sx1;
      logic signed [SCR_W-1:0] sy1;
   } rsp_type;

   function automatic logic signed [CRD_W-1:0] sat_crd(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_0000_7fff_ffff;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) begin
         return CRD_W'(hi);
      end else if (v < lo) begin
         return CRD_W'(lo);
      end
      return CRD_W'(v);
   endfunction

endpackage

>>> design/scpu_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
// no package dependencies
module scpu_div_pipe #(
   parameter int NUM_W  = 48,
   parameter int DEN_W  = 33,
   parameter int QUO_W  = 23,
   parameter int SIDE_W = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [NUM_W-1:0]  rem_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];
   logic [QUO_W-1:0]  vld_ff;
   logic [QUO_W-1:0]  vld_in;

   assign vld_in = {vld_ff[QUO_W-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   for (genvar s = 0; s < QUO_W; s++) begin : g_step
      localparam int BIT = QUO_W - 1 - s;
      logic [NUM_W-1:0]  rem_prev;
      logic [NUM_W-1:0]  rem_in;
      logic [DEN_W-1:0]  den_prev;
      logic [QUO_W-1:0]  quo_prev;
      logic [QUO_W-1:0]  quo_in;
      logic [SIDE_W-1:0] side_prev;
      logic [CMP_W-1:0]  rem_ext;
      logic [CMP_W-1:0]  shifted;
      logic              fits;

      if (s == 0) begin : g_head
         assign rem_prev  = in_num;
         assign den_prev  = in_den;
         assign quo_prev  = '0;
         assign side_prev = in_side;
      end else begin : g_body
         assign rem_prev  = rem_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign quo_prev  = quo_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      always_comb begin
         rem_ext = CMP_W'(rem_prev);
         shifted = CMP_W'(den_prev) << BIT;
         fits    = rem_ext >= shifted;
         quo_in  = quo_prev;
         quo_in[BIT] = fits;
         rem_in  = fits ? NUM_W'(rem_ext - shifted) : rem_prev;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= den_prev;
            quo_ff[s]  <= quo_in;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

>>> design/segment_clip_and_project_unit.sv
// top level of the segment clip and projection unit
// depends on scpu_pkg, scpu_div_pipe and the assertion macro header
//
// Takes one world-space segment per clock while not stalled and returns its screen
// end points one transaction per clock. The pipeline is four stages of camera
// rotation, a clip setup stage, a 17-stage divider for the clip fraction, five
// stages of interpolation and projection setup, four parallel 23-stage dividers
// for the screen coordinates and an output register. A stall on the result side
// freezes the whole pipeline and is passed to req_stall in the same cycle; nothing
// is dropped or repeated. Configuration registers are used directly by the rotation,
// clip and scaling stages, so write them only while the unit is empty.
`include "segment_clip_and_project_unit_macros.svh"
module segment_clip_and_project_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  scpu_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output scpu_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [scpu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [scpu_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int F     = scpu_pkg::FRAC_BITS;
   localparam int CW    = scpu_pkg::CRD_W;
   localparam int P1_W  = CW + scpu_pkg::TRIG_W;
   localparam int Z1_W  = P1_W + 1 - F;
   localparam int P2_W  = Z1_W + scpu_pkg::TRIG_W;
   localparam int NUM_W = CW + 1 + F;
   localparam int T_W   = F + 1;
   localparam int M_W   = T_W + 1 + CW + 1;
   localparam int PR_W  = CW + 1 + scpu_pkg::DIM_W + 1;
   localparam int DD_W  = CW + 1;
   localparam int Q_W   = scpu_pkg::SCR_W - 1;
   localparam int OV_W  = DD_W + Q_W;

   typedef struct packed {
      logic                 vis;
      logic                 clip;
      logic                 swap;
      logic signed [CW-1:0] px;
      logic signed [CW-1:0] py;
      logic signed [CW-1:0] pz;
      logic signed [CW-1:0] qx;
      logic signed [CW-1:0] qy;
      logic signed [CW-1:0] qz;
   } clip_side_type;

   typedef struct packed {
      logic vis;
      logic neg;
      logic ovf;
   } lane_side_type;

   // configuration
   logic signed [scpu_pkg::TRIG_W-1:0] yaw_cos_ff, yaw_sin_ff, pitch_cos_ff, pitch_sin_ff;
   logic [scpu_pkg::DIM_W-1:0]         scr_w_ff, scr_h_ff;
   logic [scpu_pkg::NEAR_W-1:0]        near_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_cos_ff   <= scpu_pkg::TRIG_W'(scpu_pkg::ONE_FX);
         yaw_sin_ff   <= '0;
         pitch_cos_ff <= scpu_pkg::TRIG_W'(scpu_pkg::ONE_FX);
         pitch_sin_ff <= '0;
         scr_w_ff     <= scpu_pkg::DIM_W'(scpu_pkg::DIM_RESET);
         scr_h_ff     <= scpu_pkg::DIM_W'(scpu_pkg::DIM_RESET);
         near_ff      <= scpu_pkg::NEAR_W'(scpu_pkg::NEAR_RESET);
      end else if (csr_we) begin
         case (csr_index)
            scpu_pkg::CSR_YAW_COS:   yaw_cos_ff   <= $signed(csr_wdata);
            scpu_pkg::CSR_YAW_SIN:   yaw_sin_ff   <= $signed(csr_wdata);
            scpu_pkg::CSR_PITCH_COS: pitch_cos_ff <= $signed(csr_wdata);
            scpu_pkg::CSR_PITCH_SIN: pitch_sin_ff <= $signed(csr_wdata);
            scpu_pkg::CSR_SCREEN_W:  scr_w_ff     <= csr_wdata[scpu_pkg::DIM_W-1:0];
            scpu_pkg::CSR_SCREEN_H:  scr_h_ff     <= csr_wdata[scpu_pkg::DIM_W-1:0];
            scpu_pkg::CSR_NEAR:      near_ff      <= csr_wdata[scpu_pkg::NEAR_W-1:0];
            default: ;
         endcase
      end
   end

   // global advance: the output register frees up or is empty
   logic             adv;
   logic             rsp_valid_ff;
   scpu_pkg::rsp_type rsp_data_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   logic signed [CW-1:0] in_x [2];
   logic signed [CW-1:0] in_y [2];
   logic signed [CW-1:0] in_z [2];

   assign in_x[0] = req_data.ax;
   assign in_y[0] = req_data.ay;
   assign in_z[0] = req_data.az;
   assign in_x[1] = req_data.bx;
   assign in_y[1] = req_data.by;
   assign in_z[1] = req_data.bz;

   // stage 1: yaw products
   logic signed [P1_W-1:0] s1_xc_ff [2];
   logic signed [P1_W-1:0] s1_zs_ff [2];
   logic signed [P1_W-1:0] s1_xs_ff [2];
   logic signed [P1_W-1:0] s1_zc_ff [2];
   logic signed [CW-1:0]   s1_y_ff  [2];
   logic                   s1_vld_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < 2; e++) begin
            s1_xc_ff[e] <= in_x[e] * yaw_cos_ff;
            s1_zs_ff[e] <= in_z[e] * yaw_sin_ff;
            s1_xs_ff[e] <= in_x[e] * yaw_sin_ff;
            s1_zc_ff[e] <= in_z[e] * yaw_cos_ff;
            s1_y_ff[e]  <= in_y[e];
         end
      end
   end

   // stage 2: yaw sums, depth kept at full width
   logic signed [P1_W:0]   s2_dx [2];
   logic signed [P1_W:0]   s2_sz [2];
   logic signed [CW-1:0]   s2_x_ff [2];
   logic signed [Z1_W-1:0] s2_z_ff [2];
   logic signed [CW-1:0]   s2_y_ff [2];
   logic                   s2_vld_ff;

   always_comb begin
      for (int e = 0; e < 2; e++) begin
         s2_dx[e] = (P1_W+1)'(s1_xc_ff[e]) - (P1_W+1)'(s1_zs_ff[e]);
         s2_sz[e] = (P1_W+1)'(s1_xs_ff[e]) + (P1_W+1)'(s1_zc_ff[e]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < 2; e++) begin
            s2_x_ff[e] <= scpu_pkg::sat_crd(64'(s2_dx[e] >>> F));
            s2_z_ff[e] <= Z1_W'(s2_sz[e] >>> F);
            s2_y_ff[e] <= s1_y_ff[e];
         end
      end
   end

   // stage 3: pitch products
   logic signed [P2_W-1:0] s3_yc_ff [2];
   logic signed [P2_W-1:0] s3_zs_ff [2];
   logic signed [P2_W-1:0] s3_ys_ff [2];
   logic signed [P2_W-1:0] s3_zc_ff [2];
   logic signed [CW-1:0]   s3_x_ff  [2];
   logic                   s3_vld_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < 2; e++) begin
            s3_yc_ff[e] <= s2_y_ff[e] * pitch_cos_ff;
            s3_zs_ff[e] <= s2_z_ff[e] * pitch_sin_ff;
            s3_ys_ff[e] <= s2_y_ff[e] * pitch_sin_ff;
            s3_zc_ff[e] <= s2_z_ff[e] * pitch_cos_ff;
            s3_x_ff[e]  <= s2_x_ff[e];
         end
      end
   end

   // stage 4: camera coordinates and near test
   logic signed [P2_W:0]   s4_dy [2];
   logic signed [P2_W:0]   s4_sz [2];
   logic signed [CW-1:0]   s4_zc [2];
   logic signed [CW-1:0]   near_s;
   logic signed [CW-1:0]   s4_x_ff [2];
   logic signed [CW-1:0]   s4_y_ff [2];
   logic signed [CW-1:0]   s4_z_ff [2];
   logic                   s4_fr_ff [2];
   logic                   s4_vld_ff;

   assign near_s = $signed(CW'(near_ff));

   always_comb begin
      for (int e = 0; e < 2; e++) begin
         s4_dy[e] = (P2_W+1)'(s3_yc_ff[e]) - (P2_W+1)'(s3_zs_ff[e]);
         s4_sz[e] = (P2_W+1)'(s3_ys_ff[e]) + (P2_W+1)'(s3_zc_ff[e]);
         s4_zc[e] = scpu_pkg::sat_crd(64'(s4_sz[e] >>> F));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < 2; e++) begin
            s4_x_ff[e]  <= s3_x_ff[e];
            s4_y_ff[e]  <= scpu_pkg::sat_crd(64'(s4_dy[e] >>> F));
            s4_z_ff[e]  <= s4_zc[e];
            s4_fr_ff[e] <= s4_zc[e] < near_s;
         end
      end
   end

   // stage 5: pick the end to move and set up the clip fraction
   logic                  s5_cull;
   logic                  s5_clip;
   logic                  s5_swap;
   logic signed [CW:0]    s5_n;
   logic signed [CW:0]    s5_d;
   clip_side_type         s5_side;
   logic [NUM_W-1:0]      s5_num_ff;
   logic [CW:0]           s5_den_ff;
   clip_side_type         s5_side_ff;
   logic                  s5_vld_ff;

   always_comb begin
      s5_cull = s4_fr_ff[0] && s4_fr_ff[1];
      s5_clip = s4_fr_ff[0] ^ s4_fr_ff[1];
      s5_swap = s4_fr_ff[1];
      s5_side.vis  = !s5_cull;
      s5_side.clip = s5_clip;
      s5_side.swap = s5_swap;
      s5_side.px   = s5_swap ? s4_x_ff[1] : s4_x_ff[0];
      s5_side.py   = s5_swap ? s4_y_ff[1] : s4_y_ff[0];
      s5_side.pz   = s5_swap ? s4_z_ff[1] : s4_z_ff[0];
      s5_side.qx   = s5_swap ? s4_x_ff[0] : s4_x_ff[1];
      s5_side.qy   = s5_swap ? s4_y_ff[0] : s4_y_ff[1];
      s5_side.qz   = s5_swap ? s4_z_ff[0] : s4_z_ff[1];
      s5_n = (CW+1)'(near_s) - (CW+1)'(s5_side.pz);
      s5_d = (CW+1)'(s5_side.qz) - (CW+1)'(s5_side.pz);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_num_ff  <= s5_clip ? {s5_n, {F{1'b0}}} : '0;
         s5_den_ff  <= s5_clip ? s5_d : (CW+1)'(1);
         s5_side_ff <= s5_side;
      end
   end

   // clip fraction t in [0, 1.0]
   logic          d1_vld;
   logic [T_W-1:0] d1_t;
   logic [$bits(clip_side_type)-1:0] d1_side_bits;
   clip_side_type d1_side;

   scpu_div_pipe #(
      .NUM_W  (NUM_W),
      .DEN_W  (CW + 1),
      .QUO_W  (T_W),
      .SIDE_W ($bits(clip_side_type))
   ) u_clip_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s5_vld_ff),
      .in_num    (s5_num_ff),
      .in_den    (s5_den_ff),
      .in_side   (s5_side_ff),
      .out_valid (d1_vld),
      .out_quo   (d1_t),
      .out_side  (d1_side_bits)
   );

   assign d1_side = clip_side_type'(d1_side_bits);

   // stage 6: interpolation products
   logic signed [M_W-1:0] s6_mx_ff;
   logic signed [M_W-1:0] s6_my_ff;
   clip_side_type         s6_side_ff;
   logic                  s6_vld_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_mx_ff <= $signed({1'b0, d1_t}) *
                     ((CW+1)'(d1_side.qx) - (CW+1)'(d1_side.px));
         s6_my_ff <= $signed({1'b0, d1_t}) *
                     ((CW+1)'(d1_side.qy) - (CW+1)'(d1_side.py));
         s6_side_ff <= d1_side;
      end
   end

   // stage 7: moved end point, back to a/b order
   logic signed [CW-1:0] s7_px;
   logic signed [CW-1:0] s7_py;
   logic signed [CW-1:0] s7_pz;
   logic signed [CW-1:0] s7_x_ff [2];
   logic signed [CW-1:0] s7_y_ff [2];
   logic signed [CW-1:0] s7_z_ff [2];
   logic                 s7_vis_ff;
   logic                 s7_vld_ff;

   always_comb begin
      // the moved point lies between both ends, so 32 bits hold it
      s7_px = s6_side_ff.px;
      s7_py = s6_side_ff.py;
      s7_pz = s6_side_ff.pz;
      if (s6_side_ff.clip) begin
         s7_px = CW'((CW+1)'(s6_side_ff.px) + (CW+1)'(s6_mx_ff >>> F));
         s7_py = CW'((CW+1)'(s6_side_ff.py) + (CW+1)'(s6_my_ff >>> F));
         s7_pz = near_s;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_x_ff[0] <= s6_side_ff.swap ? s6_side_ff.qx : s7_px;
         s7_y_ff[0] <= s6_side_ff.swap ? s6_side_ff.qy : s7_py;
         s7_z_ff[0] <= s6_side_ff.swap ? s6_side_ff.qz : s7_pz;
         s7_x_ff[1] <= s6_side_ff.swap ? s7_px : s6_side_ff.qx;
         s7_y_ff[1] <= s6_side_ff.swap ? s7_py : s6_side_ff.qy;
         s7_z_ff[1] <= s6_side_ff.swap ? s7_pz : s6_side_ff.qz;
         s7_vis_ff  <= s6_side_ff.vis;
      end
   end

   // stage 8: clamp depth, numerators and divisor 2z
   logic signed [CW-1:0] s8_zc [2];
   logic signed [CW:0]   s8_nx_ff [2];
   logic signed [CW:0]   s8_ny_ff [2];
   logic [DD_W-1:0]      s8_dd_ff [2];
   logic                 s8_vis_ff;
   logic                 s8_vld_ff;

   always_comb begin
      for (int e = 0; e < 2; e++) begin
         s8_zc[e] = (s7_z_ff[e] < $signed(CW'(scpu_pkg::Z_MIN))) ?
                    $signed(CW'(scpu_pkg::Z_MIN)) : s7_z_ff[e];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < 2; e++) begin
            s8_nx_ff[e] <= (CW+1)'(s7_x_ff[e]) + (CW+1)'(s8_zc[e]);
            s8_ny_ff[e] <= (CW+1)'(s8_zc[e]) - (CW+1)'(s7_y_ff[e]);
            s8_dd_ff[e] <= {s8_zc[e], 1'b0};
         end
         s8_vis_ff <= s7_vis_ff;
      end
   end

   // stage 9: scale by viewport size, one lane per screen coordinate
   logic signed [PR_W-1:0] s9_p_ff [4];
   logic [DD_W-1:0]        s9_d_ff [4];
   logic                   s9_vis_ff;
   logic                   s9_vld_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < 2; e++) begin
            s9_p_ff[2*e]   <= s8_nx_ff[e] * $signed({1'b0, scr_w_ff});
            s9_p_ff[2*e+1] <= s8_ny_ff[e] * $signed({1'b0, scr_h_ff});
            s9_d_ff[2*e]   <= s8_dd_ff[e];
            s9_d_ff[2*e+1] <= s8_dd_ff[e];
         end
         s9_vis_ff <= s8_vis_ff;
      end
   end

   // stage 10: magnitude and saturation check ahead of the divide
   logic [PR_W-1:0]  s10_mag [4];
   logic             s10_ovf [4];
   logic [PR_W-1:0]  s10_num_ff [4];
   logic [DD_W-1:0]  s10_den_ff [4];
   lane_side_type    s10_sd_ff  [4];
   logic             s10_vld_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s10_mag[k] = s9_p_ff[k][PR_W-1] ? PR_W'(-s9_p_ff[k]) : PR_W'(s9_p_ff[k]);
         s10_ovf[k] = OV_W'(s10_mag[k]) >= {s9_d_ff[k], {Q_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            s10_num_ff[k]    <= s10_ovf[k] ? '0 : s10_mag[k];
            s10_den_ff[k]    <= s9_d_ff[k];
            s10_sd_ff[k].vis <= s9_vis_ff;
            s10_sd_ff[k].neg <= s9_p_ff[k][PR_W-1];
            s10_sd_ff[k].ovf <= s10_ovf[k];
         end
      end
   end

   // valid bits of the hand-built stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         s7_vld_ff  <= 1'b0;
         s8_vld_ff  <= 1'b0;
         s9_vld_ff  <= 1'b0;
         s10_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff  <= req_valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         s5_vld_ff  <= s4_vld_ff;
         s6_vld_ff  <= d1_vld;
         s7_vld_ff  <= s6_vld_ff;
         s8_vld_ff  <= s7_vld_ff;
         s9_vld_ff  <= s8_vld_ff;
         s10_vld_ff <= s9_vld_ff;
      end
   end

   // projection dividers, lanes sx0, sy0, sx1, sy1
   logic [3:0]              pd_vld;
   logic [Q_W-1:0]          pd_quo [4];
   lane_side_type           pd_sd  [4];
   logic [scpu_pkg::SCR_W-1:0] lane_val [4];

   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [$bits(lane_side_type)-1:0] sd_bits;

      scpu_div_pipe #(
         .NUM_W  (PR_W),
         .DEN_W  (DD_W),
         .QUO_W  (Q_W),
         .SIDE_W ($bits(lane_side_type))
      ) u_proj_div (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (s10_vld_ff),
         .in_num    (s10_num_ff[k]),
         .in_den    (s10_den_ff[k]),
         .in_side   (s10_sd_ff[k]),
         .out_valid (pd_vld[k]),
         .out_quo   (pd_quo[k]),
         .out_side  (sd_bits)
      );

      assign pd_sd[k] = lane_side_type'(sd_bits);

      always_comb begin
         if (!pd_sd[k].vis) begin
            lane_val[k] = '0;
         end else if (pd_sd[k].ovf) begin
            lane_val[k] = pd_sd[k].neg ? scpu_pkg::SCR_MIN : scpu_pkg::SCR_MAX;
         end else if (pd_sd[k].neg) begin
            lane_val[k] = -{1'b0, pd_quo[k]};
         end else begin
            lane_val[k] = {1'b0, pd_quo[k]};
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= pd_vld[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.visible <= pd_sd[0].vis;
         rsp_data_ff.sx0     <= $signed(lane_val[0]);
         rsp_data_ff.sy0     <= $signed(lane_val[1]);
         rsp_data_ff.sx1     <= $signed(lane_val[2]);
         rsp_data_ff.sy1     <= $signed(lane_val[3]);
      end
   end

   `SCPU_ASSERT(a_cull_zero, clock, reset, rsp_valid && !rsp_data.visible |-> rsp_data.sx0 == 0 && rsp_data.sy0 == 0 && rsp_data.sx1 == 0 && rsp_data.sy1 == 0)
   `SCPU_ASSERT(a_back_pressure, clock, reset, rsp_valid && rsp_stall |-> req_stall)
   `SCPU_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)
   `SCPU_ASSERT(a_lanes_aligned, clock, reset, pd_vld[0] == pd_vld[1] && pd_vld[0] == pd_vld[2] && pd_vld[0] == pd_vld[3])
   `SCPU_ASSERT(a_lanes_vis, clock, reset, pd_vld[0] |-> pd_sd[0].vis == pd_sd[1].vis && pd_sd[0].vis == pd_sd[2].vis && pd_sd[0].vis == pd_sd[3].vis)

endmodule
